### design/cfs_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package cfs_pkg;

    // Stream payload sizes: used bits and byte-padded tdata widths.
    localparam int IN_BITS      = 43;
    localparam int IN_TDATA_W   = 48;
    localparam int OUT_BITS     = 63;
    localparam int OUT_TDATA_W  = 64;

    // Configuration port.
    localparam int PADDR_W      = 3;
    localparam int PDATA_W      = 32;
    localparam logic REG_DIV_ADDR = 1'b0;  // word index taken from paddr[2]
    localparam logic [15:0] DIV_ADDR_RST = 16'hFF04;

    // Instruction codes.
    localparam logic [3:0] FN_HALT  = 4'd0;
    localparam logic [3:0] FN_STOP  = 4'd1;
    localparam logic [3:0] FN_JPHL  = 4'd2;
    localparam logic [3:0] FN_JPNN  = 4'd3;
    localparam logic [3:0] FN_JR    = 4'd4;
    localparam logic [3:0] FN_SCF   = 4'd5;
    localparam logic [3:0] FN_CCF   = 4'd6;
    localparam logic [3:0] FN_DI    = 4'd7;
    localparam logic [3:0] FN_EI    = 4'd8;
    localparam logic [3:0] FN_RET   = 4'd9;
    localparam logic [3:0] FN_RETCC = 4'd10;
    localparam logic [3:0] FN_RETI  = 4'd11;
    localparam logic [3:0] FN_CALL  = 4'd12;
    localparam logic [3:0] FN_RST   = 4'd13;

    // Condition codes.
    localparam logic [2:0] CS_NZ = 3'd1;
    localparam logic [2:0] CS_NC = 3'd2;
    localparam logic [2:0] CS_Z  = 3'd3;
    localparam logic [2:0] CS_C  = 3'd4;

    // Status codes.
    localparam logic [1:0] ST_RUN  = 2'd0;
    localparam logic [1:0] ST_FIN  = 2'd1;
    localparam logic [1:0] ST_HALT = 2'd2;
    localparam logic [1:0] ST_STOP = 2'd3;

    localparam logic [3:0] RETCC_SKIP_STEP = 4'd10;
    localparam logic [3:0] STEP_MAX        = 4'd15;

    // Declared high field first so that the first field lands in the low bits.
    typedef struct packed {
        logic [7:0]  read_data;
        logic [7:0]  rst_vector;
        logic [15:0] hl_value;
        logic        irq_pending;
        logic        flag_carry_in;
        logic        flag_zero_in;
        logic [2:0]  cond_sel;
        logic        first_cycle;
        logic [3:0]  func;
    } t_in_item;

    typedef struct packed {
        logic        flags_update;
        logic        carry_out;
        logic        ime_out;
        logic [15:0] sp_out;
        logic [15:0] pc_out;
        logic [7:0]  write_byte;
        logic        bus_write;
        logic        bus_read;
        logic [15:0] bus_addr;
        logic [1:0]  status;
    } t_result;

    typedef struct packed {
        logic [15:0] pc;
        logic [15:0] sp;
        logic        ime;
        logic [3:0]  step;
        logic [15:0] target;
        logic [7:0]  rel;
    } t_state;

endpackage

`default_nettype wire

### design/cfs_apb_regs.sv
`timescale 1ns / 1ps
`default_nettype none

module cfs_apb_regs
    import cfs_pkg::*;
(
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               psel,
    input  wire logic               penable,
    input  wire logic               pwrite,
    input  wire logic [PADDR_W-1:0] paddr,
    input  wire logic [PDATA_W-1:0] pwdata,
    output logic      [PDATA_W-1:0] prdata,
    output logic                    pready,
    output logic      [15:0]        o_div_addr
);

    logic [15:0] r_div_addr;
    logic        sel_div;

    assign pready  = 1'b1;
    assign sel_div = (paddr[2] == REG_DIV_ADDR);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_div_addr <= DIV_ADDR_RST;
        end else if (psel && penable && pwrite && pready && sel_div) begin
            r_div_addr <= pwdata[15:0];
        end
    end

    // Low address bits within the word are ignored.
    assign prdata     = sel_div ? {{(PDATA_W-16){1'b0}}, r_div_addr} : '0;
    assign o_div_addr = r_div_addr;

    logic unused_addr;
    assign unused_addr = ^paddr[1:0];

endmodule

`default_nettype wire

### design/cfs_exec.sv
`timescale 1ns / 1ps
`default_nettype none

module cfs_exec
    import cfs_pkg::*;
(
    input  wire t_state           i_state,
    input  wire t_in_item         i_item,
    input  wire logic [15:0]      i_div_addr,
    output t_state                o_state,
    output t_result               o_result
);

    logic        cond;
    logic        multi;
    logic [3:0]  s;
    logic [3:0]  base;
    logic [15:0] pc_inc;
    logic [15:0] sp_dec;
    t_state      n;
    t_result     res;

    assign pc_inc = i_state.pc + 16'd1;
    assign sp_dec = i_state.sp - 16'd1;

    always_comb begin
        case (i_item.cond_sel)
            CS_NZ:   cond = !i_item.flag_zero_in;
            CS_NC:   cond = !i_item.flag_carry_in;
            CS_Z:    cond = i_item.flag_zero_in;
            CS_C:    cond = i_item.flag_carry_in;
            default: cond = 1'b1;
        endcase
    end

    always_comb begin
        case (i_item.func) inside
            FN_JPNN, FN_JR, FN_RET, FN_RETCC, FN_RETI, FN_CALL, FN_RST: multi = 1'b1;
            default: multi = 1'b0;
        endcase
    end

    always_comb begin
        n      = i_state;
        res    = '0;
        res.status = ST_FIN;
        s      = i_item.first_cycle ? 4'd0 : i_state.step;
        base   = (i_item.func == FN_RETCC) ? 4'd1 : 4'd0;
        n.step = s;
        if (multi && (s != STEP_MAX)) begin
            n.step = s + 4'd1;
        end

        case (i_item.func)
            FN_HALT: begin
                if (i_state.ime) begin
                    n.pc       = pc_inc;
                    res.status = ST_HALT;
                end else if (i_item.irq_pending) begin
                    // The first pending cycle is a wasted cycle; the next one finishes.
                    if (s == 4'd1) begin
                        n.pc = pc_inc;
                    end else begin
                        n.step     = 4'd1;
                        res.status = ST_RUN;
                    end
                end else begin
                    res.status = ST_RUN;
                end
            end
            FN_STOP: begin
                if (s == 4'd0) begin
                    n.pc          = pc_inc;
                    res.bus_addr  = i_div_addr;
                    res.bus_write = 1'b1;
                    n.step        = 4'd1;
                end
                res.status = ST_STOP;
            end
            FN_JPHL: begin
                n.pc = i_item.hl_value;
            end
            FN_JPNN: begin
                if (s == 4'd0 || s == 4'd1) begin
                    n.pc         = pc_inc;
                    res.bus_addr = pc_inc;
                    res.bus_read = 1'b1;
                    if (s == 4'd0) begin
                        n.target = {8'd0, i_item.read_data};
                    end else begin
                        n.target = {i_item.read_data, i_state.target[7:0]};
                    end
                    res.status = ST_RUN;
                end else if (s == 4'd2) begin
                    if (cond) begin
                        res.status = ST_RUN;
                    end else begin
                        n.pc = pc_inc;
                    end
                end else if (s == 4'd3) begin
                    n.pc = i_state.target;
                end
            end
            FN_JR: begin
                if (s == 4'd0) begin
                    n.pc         = pc_inc;
                    res.bus_addr = pc_inc;
                    res.bus_read = 1'b1;
                    n.rel        = i_item.read_data;
                    res.status   = ST_RUN;
                end else if (s == 4'd1) begin
                    n.pc = pc_inc;
                    if (cond) begin
                        res.status = ST_RUN;
                    end
                end else if (s == 4'd2) begin
                    n.pc = i_state.pc + {{8{i_state.rel[7]}}, i_state.rel};
                end
            end
            FN_SCF, FN_CCF: begin
                res.carry_out    = (i_item.func == FN_SCF) ? 1'b1 : !i_item.flag_carry_in;
                res.flags_update = 1'b1;
                n.pc             = pc_inc;
            end
            FN_DI, FN_EI: begin
                n.ime = (i_item.func == FN_EI);
                n.pc  = pc_inc;
            end
            FN_RET, FN_RETCC, FN_RETI: begin
                if (s == 4'd0) begin
                    res.status = ST_RUN;
                end else if (i_item.func == FN_RETCC && s == 4'd1) begin
                    if (cond) begin
                        res.status = ST_RUN;
                    end else begin
                        n.step = RETCC_SKIP_STEP;
                        n.pc   = pc_inc;
                    end
                end else if (s == base + 4'd1 || s == base + 4'd2) begin
                    res.bus_addr = i_state.sp;
                    res.bus_read = 1'b1;
                    n.sp         = i_state.sp + 16'd1;
                    if (s == base + 4'd1) begin
                        n.target = {8'd0, i_item.read_data};
                    end else begin
                        n.target = {i_item.read_data, i_state.target[7:0]};
                    end
                    res.status = ST_RUN;
                end else if (s == base + 4'd3) begin
                    n.pc = i_state.target;
                    if (i_item.func == FN_RETI) begin
                        n.ime = 1'b1;
                    end
                end
            end
            FN_CALL: begin
                if (s == 4'd0 || s == 4'd3) begin
                    res.status = ST_RUN;
                end else if (s == 4'd1) begin
                    n.pc         = pc_inc;
                    res.bus_addr = pc_inc;
                    res.bus_read = 1'b1;
                    n.target     = {8'd0, i_item.read_data};
                    res.status   = ST_RUN;
                end else if (s == 4'd2) begin
                    // Reads the high byte and also steps past it.
                    res.bus_addr = pc_inc;
                    res.bus_read = 1'b1;
                    n.target     = {i_item.read_data, i_state.target[7:0]};
                    n.pc         = i_state.pc + 16'd2;
                    if (cond) begin
                        res.status = ST_RUN;
                    end
                end else if (s == 4'd4) begin
                    n.sp           = sp_dec;
                    res.bus_addr   = sp_dec;
                    res.bus_write  = 1'b1;
                    res.write_byte = i_state.pc[15:8];
                    res.status     = ST_RUN;
                end else if (s == 4'd5) begin
                    n.sp           = sp_dec;
                    res.bus_addr   = sp_dec;
                    res.bus_write  = 1'b1;
                    res.write_byte = i_state.pc[7:0];
                    n.pc           = i_state.target;
                end
            end
            FN_RST: begin
                if (s == 4'd0) begin
                    res.status = ST_RUN;
                end else if (s == 4'd1) begin
                    n.pc           = pc_inc;
                    n.sp           = sp_dec;
                    res.bus_addr   = sp_dec;
                    res.bus_write  = 1'b1;
                    res.write_byte = pc_inc[15:8];
                    res.status     = ST_RUN;
                end else if (s == 4'd2) begin
                    n.sp           = sp_dec;
                    res.bus_addr   = sp_dec;
                    res.bus_write  = 1'b1;
                    res.write_byte = i_state.pc[7:0];
                    n.pc           = {8'd0, i_item.rst_vector};
                    res.status     = ST_RUN;
                end
            end
            default: begin
            end
        endcase

        res.pc_out  = n.pc;
        res.sp_out  = n.sp;
        res.ime_out = n.ime;
    end

    assign o_state  = n;
    assign o_result = res;

endmodule

`default_nettype wire

### design/cpu_control_flow_sequencer.sv
// Each item passes through an input register, then a result register. Throughput: one
// item per cycle while m_axis_tready does not stall the output, set by the combinational
// execution logic that also updates PC, SP, IME and the step count.
// Reset (synchronous, active low) clears PC, SP, IME, step, target and offset to zero,
// empties both stages and sets the divider register address to 0xFF04.
`timescale 1ns / 1ps
`default_nettype none

module cpu_control_flow_sequencer
    import cfs_pkg::*;
(
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   s_axis_tvalid,
    output logic                        s_axis_tready,
    // func, first_cycle, cond_sel, flag_zero_in, flag_carry_in, irq_pending,
    // hl_value, rst_vector, read_data
    input  wire logic [IN_TDATA_W-1:0]  s_axis_tdata,
    output logic                        m_axis_tvalid,
    input  wire logic                   m_axis_tready,
    // status, bus_addr, bus_read, bus_write, write_byte, pc_out, sp_out,
    // ime_out, carry_out, flags_update
    output logic      [OUT_TDATA_W-1:0] m_axis_tdata,
    input  wire logic                   psel,
    input  wire logic                   penable,
    input  wire logic                   pwrite,
    input  wire logic [PADDR_W-1:0]     paddr,
    input  wire logic [PDATA_W-1:0]     pwdata,
    output logic      [PDATA_W-1:0]     prdata,
    output logic                        pready
);

    logic        r_in_valid;
    t_in_item    r_in_item;
    logic        r_out_valid;
    t_result     r_out;
    t_state      r_state;
    t_state      n_state;
    t_result     n_out;
    logic [15:0] div_addr;
    logic        advance;

    cfs_apb_regs u_regs (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready),
        .o_div_addr (div_addr)
    );

    cfs_exec u_exec (
        .i_state    (r_state),
        .i_item     (r_in_item),
        .i_div_addr (div_addr),
        .o_state    (n_state),
        .o_result   (n_out)
    );

    // An item moves to the result register whenever that register is free or being drained.
    assign advance       = r_in_valid && (!r_out_valid || m_axis_tready);
    assign s_axis_tready = !r_in_valid || advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_in_valid <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tready && s_axis_tvalid) begin
            r_in_item <= t_in_item'(s_axis_tdata[IN_BITS-1:0]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_state     <= '0;
        end else begin
            if (advance) begin
                r_out_valid <= 1'b1;
                r_state     <= n_state;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out <= n_out;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {{(OUT_TDATA_W-OUT_BITS){1'b0}}, r_out};

    logic unused_pad;
    assign unused_pad = ^s_axis_tdata[IN_TDATA_W-1:IN_BITS];

    // The architectural state only moves when an item passes through execution.
    a_state_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !advance |=> $stable(r_state))
        else $error("sequencer state changed without an item");

    a_one_access: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> !(r_out.bus_read && r_out.bus_write))
        else $error("read and write in the same cycle");

    a_flags_no_bus: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && r_out.flags_update) |-> !(r_out.bus_read || r_out.bus_write))
        else $error("flag update with a bus access");

    a_halt_ime: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && r_out.status == ST_HALT) |-> r_out.ime_out)
        else $error("halted status with interrupts disabled");

    a_pc_reported: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        advance |=> (r_out.pc_out == r_state.pc && r_out.sp_out == r_state.sp))
        else $error("reported PC or SP differs from the state");

endmodule

`default_nettype wire
